/* src/tournament_branch_predictor_macros.svh */
// Assertion macros for the tournament branch predictor.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tbp_pkg.sv */
// Shared types, constants and counter functions for the tournament branch predictor.
// No dependencies.
package tbp_pkg;

   // Field widths and parameter defaults
   localparam int PC_W               = 32;
   localparam int CTR_W              = 2;
   localparam int DEF_TABLE_ENTRIES  = 1024;
   localparam int DEF_HISTORY_LENGTH = 10;

   // Counter reset values and limits
   localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN    = 2'd2;
   localparam logic [CTR_W-1:0] CTR_STRONG_LOCAL  = 2'd0;
   localparam logic [CTR_W-1:0] CTR_MAX           = 2'd3;
   localparam logic [CTR_W-1:0] CTR_MIN           = 2'd0;

   // One set of counters: local, global and chooser
   typedef struct packed {
      logic [CTR_W-1:0] chs_ctr;
      logic [CTR_W-1:0] loc_ctr;
      logic [CTR_W-1:0] glb_ctr;
   } ctr_set_type;

   // Result of one branch
   typedef struct packed {
      logic             prediction;
      logic             local_prediction;
      logic             global_prediction;
      logic [CTR_W-1:0] chooser_value;
      logic             hit;
   } pred_result_type;

   // 2-bit saturating step
   function automatic logic [CTR_W-1:0] sat_step(input logic [CTR_W-1:0] v,
                                                 input logic up);
      logic [CTR_W-1:0] r;
      r = v;
      if (up) begin
         if (v != CTR_MAX) r = v + CTR_W'(1);
      end else begin
         if (v != CTR_MIN) r = v - CTR_W'(1);
      end
      return r;
   endfunction

   // Upper half of the counter range means taken
   function automatic logic says_taken(input logic [CTR_W-1:0] v);
      return v[CTR_W-1];
   endfunction

endpackage

/* src/tbp_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Depends on nothing; read returns the old entry on a same-cycle write.
module tbp_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
   end

   // Read port, registered output
   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/tbp_update.sv */
// Prediction and training logic for one branch given its current counters.
// Depends on tbp_pkg.
module tbp_update
   import tbp_pkg::*;
(
   input  ctr_set_type     cur,
   input  logic            taken,
   output ctr_set_type     upd,
   output pred_result_type res
);

   logic lp;
   logic gp;
   logic pick_global;
   logic pred;

   // Predictions from the counters before training
   always_comb begin
      lp          = says_taken(cur.loc_ctr);
      gp          = says_taken(cur.glb_ctr);
      pick_global = says_taken(cur.chs_ctr);
      pred        = pick_global ? gp : lp;
   end

   // Train both components; chooser moves only on disagreement
   always_comb begin
      upd.loc_ctr = sat_step(cur.loc_ctr, taken);
      upd.glb_ctr = sat_step(cur.glb_ctr, taken);
      if (lp != gp) upd.chs_ctr = sat_step(cur.chs_ctr, gp == taken);
      else          upd.chs_ctr = cur.chs_ctr;
   end

   // Result fields; chooser shown after training
   always_comb begin
      res.prediction        = pred;
      res.local_prediction  = lp;
      res.global_prediction = gp;
      res.chooser_value     = upd.chs_ctr;
      res.hit               = (pred == taken);
   end

endmodule

/* src/tournament_branch_predictor.sv */
// Tournament branch predictor top level: control, history, table clearing, output register.
// Depends on tbp_pkg, tbp_ram, tbp_update and tournament_branch_predictor_macros.svh.
//
// Takes one resolved branch per clock cycle while the output is not stalled and returns its
// result after a memory read, then a compute and write-back into the output register. The
// rate is set by the read-modify-write round through the two counter memories (local and
// chooser share one, global has the other); a write from the previous branch is forwarded
// into the next read. After reset a clearing pass over all TABLE_ENTRIES entries loads the
// counter reset values, and req_ready stays low until it ends.
// TABLE_ENTRIES must be a power of two; the tables are indexed by the low address bits and
// the low history bits.
`include "tournament_branch_predictor_macros.svh"

module tournament_branch_predictor
   import tbp_pkg::*;
#(
   parameter int TABLE_ENTRIES  = DEF_TABLE_ENTRIES,
   parameter int HISTORY_LENGTH = DEF_HISTORY_LENGTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PC_W-1:0]  req_pc,
   input  logic             req_taken,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_prediction,
   output logic             rsp_local_prediction,
   output logic             rsp_global_prediction,
   output logic [CTR_W-1:0] rsp_chooser_value,
   output logic             rsp_hit
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int HX_W   = (HISTORY_LENGTH > IDX_W) ? HISTORY_LENGTH : IDX_W;
   localparam int LC_W   = 2 * CTR_W;

   // Control state
   logic                      clearing_ff, clearing_in;
   logic [IDX_W-1:0]          clr_idx_ff, clr_idx_in;
   logic [HISTORY_LENGTH-1:0] history_ff, history_in;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      fwd_valid_ff, fwd_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [IDX_W-1:0]          s1_li_ff;
   logic [IDX_W-1:0]          s1_gi_ff;
   logic                      s1_taken_ff;
   logic [IDX_W-1:0]          fwd_li_ff;
   logic [IDX_W-1:0]          fwd_gi_ff;
   logic [LC_W-1:0]           fwd_lc_ff;
   logic [CTR_W-1:0]          fwd_g_ff;
   pred_result_type           rsp_ff;

   logic                      req_xfer;
   logic                      s1_adv;
   logic [IDX_W-1:0]          req_li;
   logic [IDX_W-1:0]          req_gi;
   logic [HX_W-1:0]           hist_ext;

   logic                      lc_we;
   logic [IDX_W-1:0]          lc_waddr;
   logic [LC_W-1:0]           lc_wdata;
   logic [LC_W-1:0]           lc_rdata;
   logic                      g_we;
   logic [IDX_W-1:0]          g_waddr;
   logic [CTR_W-1:0]          g_wdata;
   logic [CTR_W-1:0]          g_rdata;

   logic [LC_W-1:0]           lc_cur;
   logic [CTR_W-1:0]          g_cur;
   ctr_set_type               cur;
   ctr_set_type               upd;
   pred_result_type           res;

   logic                      comp_agree;
   logic                      chs_held;

   // Handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign req_xfer  = req_valid && req_ready;

   // Table indexes: low address bits and low history bits
   assign hist_ext = HX_W'(history_ff);
   assign req_li   = req_pc[IDX_W-1:0];
   assign req_gi   = hist_ext[IDX_W-1:0];

   // Memory write ports: clearing pass or write-back from the compute stage
   always_comb begin
      lc_we    = clearing_ff || s1_adv;
      g_we     = clearing_ff || s1_adv;
      lc_waddr = clearing_ff ? clr_idx_ff : s1_li_ff;
      g_waddr  = clearing_ff ? clr_idx_ff : s1_gi_ff;
      lc_wdata = clearing_ff ? {CTR_STRONG_LOCAL, CTR_WEAK_TAKEN} : {upd.chs_ctr, upd.loc_ctr};
      g_wdata  = clearing_ff ? CTR_WEAK_TAKEN : upd.glb_ctr;
   end

   tbp_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (LC_W)
   ) u_lc_ram (
      .clock (clock),
      .we    (lc_we),
      .waddr (lc_waddr),
      .wdata (lc_wdata),
      .re    (req_xfer),
      .raddr (req_li),
      .rdata (lc_rdata)
   );

   tbp_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (CTR_W)
   ) u_g_ram (
      .clock (clock),
      .we    (g_we),
      .waddr (g_waddr),
      .wdata (g_wdata),
      .re    (req_xfer),
      .raddr (req_gi),
      .rdata (g_rdata)
   );

   // Forward the last write over a read that saw the old entry
   always_comb begin
      lc_cur = (fwd_valid_ff && (fwd_li_ff == s1_li_ff)) ? fwd_lc_ff : lc_rdata;
      g_cur  = (fwd_valid_ff && (fwd_gi_ff == s1_gi_ff)) ? fwd_g_ff : g_rdata;
      cur.chs_ctr = lc_cur[LC_W-1:CTR_W];
      cur.loc_ctr = lc_cur[CTR_W-1:0];
      cur.glb_ctr = g_cur;
   end

   tbp_update u_update (
      .cur   (cur),
      .taken (s1_taken_ff),
      .upd   (upd),
      .res   (res)
   );

   // Next-state logic for control
   always_comb begin
      clearing_in  = clearing_ff;
      clr_idx_in   = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == {IDX_W{1'b1}}) clearing_in = 1'b0;
      end
      history_in   = req_xfer ? {history_ff[HISTORY_LENGTH-2:0], req_taken} : history_ff;
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_adv);
      fwd_valid_in = fwd_valid_ff || s1_adv;
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         history_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_idx_ff   <= clr_idx_in;
         history_ff   <= history_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: compute stage, forwarding copy, output
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_li_ff    <= req_li;
         s1_gi_ff    <= req_gi;
         s1_taken_ff <= req_taken;
      end
      if (s1_adv) begin
         fwd_li_ff <= s1_li_ff;
         fwd_gi_ff <= s1_gi_ff;
         fwd_lc_ff <= {upd.chs_ctr, upd.loc_ctr};
         fwd_g_ff  <= upd.glb_ctr;
         rsp_ff    <= res;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_prediction        = rsp_ff.prediction;
   assign rsp_local_prediction  = rsp_ff.local_prediction;
   assign rsp_global_prediction = rsp_ff.global_prediction;
   assign rsp_chooser_value     = rsp_ff.chooser_value;
   assign rsp_hit               = rsp_ff.hit;

   // Terms for the chooser check
   assign comp_agree = (res.local_prediction == res.global_prediction);
   assign chs_held   = (upd.chs_ctr == cur.chs_ctr);

   // Checks
   `TBP_ASSERT_NOW(a_no_xfer_clearing, req_xfer, !clearing_ff, "transfer during clearing pass")
   `TBP_ASSERT_NEXT(a_xfer_reaches_s1, req_xfer, s1_valid_ff, "accepted branch lost")
   `TBP_ASSERT_NOW(a_no_rsp_overwrite, s1_adv, !rsp_valid_ff || rsp_ready, "output overwritten")
   `TBP_ASSERT_NOW(a_chooser_agree, s1_adv && comp_agree, chs_held, "chooser moved on agreement")

endmodule
